@@ sv/assert_macros.svh @@
// Assertion macros used by the level meter's checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property of the block's behaviour, sampled on the rising clock edge.
`define ALM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("level meter: behaviour check failed");

// Checks a rule of the result channel handshake.
`define ALM_PROTO(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("level meter: result channel protocol check failed");

`endif

@@ sv/almph_pkg.sv @@
// Package with the constants shared by the level meter and its checker.
package almph_pkg;

   // Parameter defaults.
   localparam int MAX_CHANNELS_DEF     = 8;
   localparam int FRAME_COUNT_BITS_DEF = 16;
   localparam int LEVEL_FRAC_BITS_DEF  = 16;

   // Field widths.
   localparam int SAMPLE_W  = 16;
   localparam int CHAN_W    = 3;
   localparam int CFG_W     = 17;
   localparam int OUT_W     = 17;
   localparam int CC_W      = 4;
   localparam int CSR_IDX_W = 2;
   localparam int SUM_W     = 32;
   localparam int MUL_W     = 34;
   localparam int PROD_W    = 68;

   // Channel field spans eight channels.
   localparam int CHAN_SPAN = 8;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_DECAY       = 2'd2;

   // Register reset values and the Q16 unit.
   localparam logic [CC_W-1:0]  CC_RESET = 4'd1;
   localparam logic [CFG_W-1:0] Q16_ONE  = 17'd65536;
   localparam logic [CFG_W-1:0] W_RESET  = 17'd65536;
   localparam logic [CFG_W-1:0] D_RESET  = 17'd1966;

   // 0.2*log10(2) in Q32, turns log2 into the dB/100 scale.
   localparam logic signed [MUL_W-1:0] LOG_COEF = 34'sd258582797;

endpackage

@@ sv/audio_level_meter_peak_hold.sv @@
// Audio level meter: per-channel mean magnitude, smoothed level and decaying peak on a log scale.
// A sample without the buffer end flag is taken in the idle state, and the next may follow at once.
// At buffer end, if any frame was counted, each active channel goes through a restoring divider for
// the mean, then two logs of 16 squarings each on the one shared 34x34 multiplier; results leave
// one per channel and the block stalls requests until the last is taken.
// Reset (synchronous) clears sums, frame count and levels and restores the register defaults.
module audio_level_meter_peak_hold #(
   parameter int MAX_CHANNELS     = almph_pkg::MAX_CHANNELS_DEF,
   parameter int FRAME_COUNT_BITS = almph_pkg::FRAME_COUNT_BITS_DEF,
   parameter int LEVEL_FRAC_BITS  = almph_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [almph_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [almph_pkg::CHAN_W-1:0]         req_channel,
   input  logic                                 req_buffer_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [almph_pkg::CHAN_W-1:0]         rsp_out_channel,
   output logic [almph_pkg::OUT_W-1:0]          rsp_average_level,
   output logic [almph_pkg::OUT_W-1:0]          rsp_peak_level,
   output logic                                 rsp_last_channel,
   input  logic                                 csr_write_enable,
   input  logic [almph_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [almph_pkg::CFG_W-1:0]          csr_write_data
);

   localparam int NCH = (MAX_CHANNELS < almph_pkg::CHAN_SPAN) ? MAX_CHANNELS
                                                               : almph_pkg::CHAN_SPAN;
   localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int FCB = FRAME_COUNT_BITS;
   localparam int LW  = LEVEL_FRAC_BITS + 1;
   localparam int EW  = $clog2(LW);
   localparam int SHL = (LEVEL_FRAC_BITS >= 16) ? LEVEL_FRAC_BITS - 16 : 0;
   localparam int SHR = (LEVEL_FRAC_BITS < 16) ? 16 - LEVEL_FRAC_BITS : 0;
   localparam int SW  = almph_pkg::SUM_W;
   localparam int MW  = almph_pkg::MUL_W;
   localparam int PW  = almph_pkg::PROD_W;
   localparam int OW  = almph_pkg::OUT_W;
   localparam int CW  = almph_pkg::CC_W;

   localparam logic [LW-1:0]  LVL_ONE = LW'(1) << LEVEL_FRAC_BITS;
   localparam logic [FCB-1:0] FC_MAX  = {FCB{1'b1}};

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_START = 14'b00000000000010,
      ST_LOAD  = 14'b00000000000100,
      ST_DIV   = 14'b00000000001000,
      ST_MULW  = 14'b00000000010000,
      ST_AVG   = 14'b00000000100000,
      ST_MULP  = 14'b00000001000000,
      ST_PEAK  = 14'b00000010000000,
      ST_LNORM = 14'b00000100000000,
      ST_LSQ   = 14'b00001000000000,
      ST_LSTEP = 14'b00010000000000,
      ST_LMUL  = 14'b00100000000000,
      ST_LOUT  = 14'b01000000000000,
      ST_OUT   = 14'b10000000000000
   } state_type;

   state_type                 state_ff;
   logic [CW-1:0]             cc_ff;
   logic [OW-1:0]             w_ff;
   logic [OW-1:0]             d_ff;
   logic [SW-1:0]             sum_ff [NCH];
   logic [FCB-1:0]            fc_ff;
   logic [LW-1:0]             avg_ff [NCH];
   logic [LW-1:0]             pk_ff  [NCH];
   logic [IW-1:0]             k_ff;
   logic [4:0]                div_cnt_ff;
   logic [SW-1:0]             dq_ff;
   logic [FCB-1:0]            rem_ff;
   logic [LW-1:0]             avg_new_ff;
   logic [LW-1:0]             pk_new_ff;
   logic                      log_sel_ff;
   logic [EW-1:0]             e_ff;
   logic [31:0]               m_ff;
   logic [15:0]               frac_ff;
   logic [3:0]                it_ff;
   logic signed [PW-1:0]      prod_ff;
   logic [OW-1:0]             avg_log_ff;
   logic                      rsp_valid_ff;
   logic [almph_pkg::CHAN_W-1:0] rsp_ch_ff;
   logic [OW-1:0]             rsp_avg_ff;
   logic [OW-1:0]             rsp_pk_ff;
   logic                      rsp_last_ff;

   logic [CW-1:0]             nch;
   logic                      is_last;
   logic                      req_acc;
   logic                      ch_ok;
   logic [IW-1:0]             ch_idx;
   logic [OW-1:0]             mag;
   logic [SW:0]               sum_add;
   logic [FCB:0]              div_shift;
   logic                      div_ge;
   logic [FCB:0]              div_rem;
   logic [SW-1:0]             x_lvl;
   logic signed [MW-1:0]      mul_a;
   logic signed [MW-1:0]      mul_b;
   logic signed [PW-1:0]      avg_sum;
   logic [LW-1:0]             avg_clamp;
   logic signed [PW-1:0]      pk_dec;
   logic [LW-1:0]             pk_clamp;
   logic [LW-1:0]             lvl;
   logic [EW-1:0]             msb;
   logic [31:0]               m_norm;
   logic [31:0]               sq;
   logic signed [EW:0]        ediff;
   logic signed [EW+16:0]     l2;
   logic signed [PW-1:0]      log_sum;
   logic                      log_done;
   logic [OW-1:0]             log_val;

   // Active channel count, with zero acting as one and large values capped.
   always_comb begin
      if (cc_ff == '0) begin
         nch = CW'(1);
      end else if (cc_ff > CW'(NCH)) begin
         nch = CW'(NCH);
      end else begin
         nch = cc_ff;
      end
   end

   assign is_last = (CW'(k_ff) == (nch - CW'(1)));

   // Request acceptance and magnitude accumulation.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign ch_ok     = (CW'(req_channel) < nch);
   assign ch_idx    = req_channel[IW-1:0];
   assign mag       = req_sample[almph_pkg::SAMPLE_W-1]
                      ? (almph_pkg::Q16_ONE - {1'b0, req_sample})
                      : {1'b0, req_sample};
   assign sum_add   = {1'b0, sum_ff[ch_idx]} + (SW+1)'(mag);

   // One restoring divider step per cycle.
   assign div_shift = {rem_ff, dq_ff[SW-1]};
   assign div_ge    = (div_shift >= {1'b0, fc_ff});
   assign div_rem   = div_ge ? (div_shift - {1'b0, fc_ff}) : div_shift;
   assign x_lvl     = (LEVEL_FRAC_BITS >= 16) ? (dq_ff << SHL) : (dq_ff >> SHR);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MULW: begin
            mul_a = $signed({2'b00, x_lvl}) - $signed(MW'(avg_ff[k_ff]));
            mul_b = $signed(MW'(w_ff));
         end
         ST_MULP: begin
            mul_a = $signed(MW'(pk_ff[k_ff]));
            mul_b = $signed(MW'(d_ff));
         end
         ST_LSQ: begin
            mul_a = $signed({2'b00, m_ff});
            mul_b = $signed({2'b00, m_ff});
         end
         ST_LMUL: begin
            mul_a = MW'(l2);
            mul_b = almph_pkg::LOG_COEF;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Smoothed level update and peak decay, both rounded half up and clamped.
   always_comb begin
      avg_sum = $signed(PW'(avg_ff[k_ff])) + ((prod_ff + PW'(32768)) >>> 16);
      if (avg_sum < 0) begin
         avg_clamp = '0;
      end else if (avg_sum > $signed(PW'(LVL_ONE))) begin
         avg_clamp = LVL_ONE;
      end else begin
         avg_clamp = avg_sum[LW-1:0];
      end
      pk_dec = $signed(PW'(pk_ff[k_ff])) - ((prod_ff + PW'(32768)) >>> 16);
      if (pk_dec < $signed(PW'(avg_new_ff))) begin
         pk_clamp = avg_new_ff;
      end else if (pk_dec > $signed(PW'(LVL_ONE))) begin
         pk_clamp = LVL_ONE;
      end else begin
         pk_clamp = pk_dec[LW-1:0];
      end
   end

   // Log stage: normalisation of the level and the final scaling.
   assign lvl = log_sel_ff ? pk_new_ff : avg_new_ff;

   always_comb begin
      msb = '0;
      for (int i = 0; i < LW; i++) begin
         if (lvl[i]) begin
            msb = EW'(i);
         end
      end
   end

   assign m_norm  = 32'(lvl) << (5'd30 - 5'(msb));
   assign sq      = prod_ff[61:30];
   assign ediff   = $signed({1'b0, e_ff}) - $signed((EW+1)'(LEVEL_FRAC_BITS));
   assign l2      = $signed({ediff, frac_ff});
   assign log_sum = PW'(65536) + ((prod_ff + (PW'(1) <<< 31)) >>> 32);

   always_comb begin
      log_done = 1'b0;
      log_val  = '0;
      if (state_ff == ST_LNORM && lvl == '0) begin
         log_done = 1'b1;
      end else if (state_ff == ST_LOUT) begin
         log_done = 1'b1;
         if (log_sum < 0) begin
            log_val = '0;
         end else if (log_sum > PW'(65536)) begin
            log_val = almph_pkg::Q16_ONE;
         end else begin
            log_val = log_sum[OW-1:0];
         end
      end
   end

   // Shared multiplier with its registered product.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Configuration registers; weights above one act as one.
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= almph_pkg::CC_RESET;
         w_ff  <= almph_pkg::W_RESET;
         d_ff  <= almph_pkg::D_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            almph_pkg::CSR_CHANNEL_COUNT: begin
               cc_ff <= csr_write_data[CW-1:0];
            end
            almph_pkg::CSR_SMOOTHING_WEIGHT: begin
               w_ff <= (csr_write_data > almph_pkg::Q16_ONE) ? almph_pkg::Q16_ONE
                                                              : csr_write_data;
            end
            almph_pkg::CSR_PEAK_DECAY: begin
               d_ff <= (csr_write_data > almph_pkg::Q16_ONE) ? almph_pkg::Q16_ONE
                                                              : csr_write_data;
            end
            default: begin
               cc_ff <= cc_ff;
            end
         endcase
      end
   end

   // Sequencer: accumulation, then per channel divide, update, two logs and the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fc_ff        <= '0;
         k_ff         <= '0;
         log_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NCH; i++) begin
            sum_ff[i] <= '0;
            avg_ff[i] <= '0;
            pk_ff[i]  <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (ch_ok) begin
                     sum_ff[ch_idx] <= sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
                     if (CW'(req_channel) == (nch - CW'(1)) && fc_ff != FC_MAX) begin
                        fc_ff <= fc_ff + FCB'(1);
                     end
                  end
                  if (req_buffer_end) begin
                     state_ff <= ST_START;
                  end
               end
            end
            ST_START: begin
               if (fc_ff == '0) begin
                  fc_ff <= '0;
                  for (int i = 0; i < NCH; i++) begin
                     sum_ff[i] <= '0;
                  end
                  state_ff <= ST_IDLE;
               end else begin
                  k_ff     <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               dq_ff      <= sum_ff[k_ff];
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               dq_ff      <= {dq_ff[SW-2:0], div_ge};
               rem_ff     <= div_rem[FCB-1:0];
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == 5'd31) begin
                  state_ff <= ST_MULW;
               end
            end
            ST_MULW: begin
               state_ff <= ST_AVG;
            end
            ST_AVG: begin
               avg_new_ff <= avg_clamp;
               state_ff   <= ST_MULP;
            end
            ST_MULP: begin
               state_ff <= ST_PEAK;
            end
            ST_PEAK: begin
               pk_new_ff    <= pk_clamp;
               avg_ff[k_ff] <= avg_new_ff;
               pk_ff[k_ff]  <= pk_clamp;
               log_sel_ff   <= 1'b0;
               state_ff     <= ST_LNORM;
            end
            ST_LNORM: begin
               e_ff    <= msb;
               m_ff    <= m_norm;
               frac_ff <= '0;
               it_ff   <= '0;
               if (!log_done) begin
                  state_ff <= ST_LSQ;
               end
            end
            ST_LSQ: begin
               state_ff <= ST_LSTEP;
            end
            ST_LSTEP: begin
               if (sq[31]) begin
                  m_ff    <= {1'b0, sq[31:1]};
                  frac_ff <= {frac_ff[14:0], 1'b1};
               end else begin
                  m_ff    <= sq;
                  frac_ff <= {frac_ff[14:0], 1'b0};
               end
               it_ff <= it_ff + 4'd1;
               state_ff <= (it_ff == 4'd15) ? ST_LMUL : ST_LSQ;
            end
            ST_LMUL: begin
               state_ff <= ST_LOUT;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (is_last) begin
                     fc_ff <= '0;
                     for (int i = 0; i < NCH; i++) begin
                        sum_ff[i] <= '0;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + IW'(1);
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= state_ff;
            end
         endcase

         // A finished log goes to the average slot first, then completes the result.
         if (log_done) begin
            if (!log_sel_ff) begin
               avg_log_ff <= log_val;
               log_sel_ff <= 1'b1;
               state_ff   <= ST_LNORM;
            end else begin
               rsp_valid_ff <= 1'b1;
               rsp_ch_ff    <= almph_pkg::CHAN_W'(k_ff);
               rsp_avg_ff   <= avg_log_ff;
               rsp_pk_ff    <= log_val;
               rsp_last_ff  <= is_last;
               state_ff     <= ST_OUT;
            end
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_ch_ff;
   assign rsp_average_level = rsp_avg_ff;
   assign rsp_peak_level    = rsp_pk_ff;
   assign rsp_last_channel  = rsp_last_ff;

endmodule

@@ sv/almph_checker.sv @@
// Port-level checker for the level meter and its bind to the top level.
`include "assert_macros.svh"

module almph_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [almph_pkg::OUT_W-1:0]   rsp_average_level,
   input logic [almph_pkg::OUT_W-1:0]   rsp_peak_level,
   input logic                          rsp_last_channel
);

   // A stalled result keeps its levels.
   `ALM_PROTO(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average_level) && $stable(rsp_peak_level))

   // No request is taken while a result waits.
   `ALM_ASSERT(a_busy_with_rsp, rsp_valid |-> req_stall)

   // The peak never reads below the smoothed level, and both stay within full scale.
   `ALM_ASSERT(a_peak_above_avg, rsp_valid |-> rsp_peak_level >= rsp_average_level && rsp_peak_level <= almph_pkg::Q16_ONE)

   // The next channel's result needs a fresh divide, so it never follows directly.
   `ALM_ASSERT(a_rsp_gap, rsp_valid && !rsp_stall && !rsp_last_channel |=> !rsp_valid)

endmodule

bind audio_level_meter_peak_hold almph_checker u_almph_checker (.*);
